// ----- design/mcsr_pkg.sv -----
// ----------------------------------------------------------------------------
// Memory card serial responder package
// Card size, protocol byte codes and the exchange phase encoding.
// ----------------------------------------------------------------------------
package mcsr_pkg;

	// Card storage geometry. The card size is a power of two.
	localparam int CARD_BYTES   = 131072;
	localparam int ADDR_W       = $clog2(CARD_BYTES);
	localparam int SECTOR_BYTES = 128;
	localparam int SECTOR_SH    = $clog2(SECTOR_BYTES);
	localparam int SECTOR_W     = 16;

	// Protocol bytes.
	localparam logic [7:0] BYTE_IDLE     = 8'hff;
	localparam logic [7:0] BYTE_ACCESS   = 8'h81;
	localparam logic [7:0] BYTE_ACCESS_B = 8'h01;
	localparam logic [7:0] BYTE_FLAG_RST = 8'h08;
	localparam logic [7:0] BYTE_ID1      = 8'h5a;
	localparam logic [7:0] BYTE_ACK_A    = 8'h5c;
	localparam logic [7:0] BYTE_ACK_B    = 8'h5d;
	localparam logic [7:0] BYTE_END      = 8'h47;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] CMD_READ      = 8'h52;
	localparam logic [7:0] CMD_WRITE     = 8'h57;
	localparam logic [7:0] SECTOR_COUNT  = 8'(SECTOR_BYTES);

	// Exchange phases, in protocol order; advancing adds one.
	typedef enum logic [4:0] {
		PH_IDLE,
		PH_FLAG,
		PH_ID1,
		PH_ID2,
		PH_R_RX_MSB,
		PH_R_RX_LSB,
		PH_R_ACK1,
		PH_R_ACK2,
		PH_R_TX_MSB,
		PH_R_TX_LSB,
		PH_R_DATA,
		PH_R_CHK,
		PH_R_END,
		PH_W_RX_MSB,
		PH_W_RX_LSB,
		PH_W_DATA,
		PH_W_CHK,
		PH_W_CHK2,
		PH_W_ACK1,
		PH_W_ACK2,
		PH_W_END
	} phase_t;

endpackage

// ----- design/mcsr_req_if.sv -----
// ----------------------------------------------------------------------------
// Host request channel
// Carries one host byte or a deselect per item, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcsr_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] host_byte;
	logic       deselect;

	modport source (output valid, output host_byte, output deselect, input ready);
	modport sink (input valid, input host_byte, input deselect, output ready);
endinterface

// ----- design/mcsr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Card response channel
// Carries the reply byte, acknowledge and sector write count per item.
// ----------------------------------------------------------------------------
interface mcsr_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reply_byte;
	logic        acknowledge;
	logic [31:0] sectors_written;

	modport source (output valid, output reply_byte, output acknowledge,
		output sectors_written, input ready);
	modport sink (input valid, input reply_byte, input acknowledge,
		input sectors_written, output ready);
endinterface

// ----- design/memory_card_serial_responder.sv -----
// ----------------------------------------------------------------------------
// Memory card serial responder
// Card side of a byte-serial memory card link with sector read and write.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel brings one item per byte exchange: a host byte, or a
//   deselect that ends the transaction. For every request item the response
//   channel delivers exactly one item: reply byte, acknowledge bit and the
//   running count of completed sector writes.
//   An item is presented on the response channel from the cycle after it is
//   accepted. A new item is accepted every cycle while the receiver keeps up;
//   the card storage read port is kept pointed at the current byte address,
//   so read data is already registered when a data exchange arrives.
//   The response sits in an output register; the request side stays ready
//   while that register is empty or being taken in the same cycle. When the
//   receiver stalls, the response holds and further requests wait.
//   After reset the card storage is cleared to zero by a pass that writes one
//   byte per cycle, all 131072 bytes (CARD_BYTES); no item is accepted
//   during that pass. Reset also sets the flag byte to 0x08 and the phase to
//   idle.
// ----------------------------------------------------------------------------
module memory_card_serial_responder
	import mcsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mcsr_req_if.sink    request,
	mcsr_rsp_if.source  response
);

	// Protocol state.
	phase_t              phase_q, phase_d;
	logic [7:0]          command_q, command_d;
	logic [7:0]          flag_q, flag_d;
	logic [7:0]          sect_hi_q, sect_hi_d;
	logic [7:0]          sect_lo_q, sect_lo_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic [7:0]          left_q, left_d;
	logic [7:0]          chk_q, chk_d;
	logic [31:0]         wcount_q, wcount_d;

	// Output register.
	logic                rsp_valid_q;
	logic [7:0]          reply_q;
	logic                ack_q;
	logic [31:0]         count_q;

	// Storage and clearing pass.
	logic [7:0]          mem [CARD_BYTES];
	logic [7:0]          rd_q;
	logic                clr_busy_q;
	logic [ADDR_W-1:0]   clr_addr_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_wa;
	logic [7:0]          mem_wd;
	logic                data_we;

	// Exchange logic.
	logic                accept;
	logic [7:0]          b;
	logic [7:0]          reply;
	logic                ack;
	logic [7:0]          left_dec;
	logic                access_repeat;
	logic [SECTOR_W-1:0] sector;
	logic [ADDR_W+SECTOR_W+SECTOR_SH-1:0] sector_addr;

	// Handshake: take an item when the output register is free or draining.
	assign request.ready = !clr_busy_q && (!rsp_valid_q || response.ready);
	assign accept        = request.valid && request.ready;
	assign b             = request.host_byte;

	assign left_dec      = left_q - 8'd1;
	assign access_repeat = (b == BYTE_ACCESS) || (b == BYTE_ACCESS_B);

	// Sector start address, wrapped to the card size.
	assign sector      = {sect_hi_q, b};
	assign sector_addr = {{ADDR_W{1'b0}}, sector, {SECTOR_SH{1'b0}}};

	// Phase next state.
	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (request.deselect) begin
				phase_d = PH_IDLE;
			end else begin
				case (phase_q)
					PH_FLAG: begin
						phase_d = access_repeat ? PH_IDLE : PH_ID1;
					end
					PH_ID2: begin
						if (command_q == CMD_READ) begin
							phase_d = PH_R_RX_MSB;
						end else if (command_q == CMD_WRITE) begin
							phase_d = PH_W_RX_MSB;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_R_DATA: begin
						phase_d = (left_dec == 8'd0) ? PH_R_CHK : PH_R_DATA;
					end
					PH_W_DATA: begin
						phase_d = (left_dec == 8'd0) ? PH_W_CHK : PH_W_DATA;
					end
					PH_R_END, PH_W_END: begin
						phase_d = PH_IDLE;
					end
					PH_IDLE, PH_ID1, PH_R_RX_MSB, PH_R_RX_LSB, PH_R_ACK1,
					PH_R_ACK2, PH_R_TX_MSB, PH_R_TX_LSB, PH_R_CHK,
					PH_W_RX_MSB, PH_W_RX_LSB, PH_W_CHK, PH_W_CHK2,
					PH_W_ACK1, PH_W_ACK2: begin
						phase_d = phase_t'(phase_q + 5'd1);
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	// Reply, acknowledge and datapath updates for the exchange.
	always_comb begin
		reply     = BYTE_IDLE;
		ack       = 1'b1;
		command_d = command_q;
		flag_d    = flag_q;
		sect_hi_d = sect_hi_q;
		sect_lo_d = sect_lo_q;
		addr_d    = addr_q;
		left_d    = left_q;
		chk_d     = chk_q;
		wcount_d  = wcount_q;
		data_we   = 1'b0;
		if (accept && request.deselect) begin
			ack = 1'b0;
		end else if (accept) begin
			case (phase_q)
				PH_IDLE: begin
					reply = BYTE_IDLE;
				end
				PH_FLAG: begin
					command_d = b;
					if (!access_repeat) begin
						reply  = flag_q;
						flag_d = BYTE_ZERO;
					end
				end
				PH_ID1: begin
					reply = BYTE_ID1;
				end
				PH_ID2: begin
					if ((command_q == CMD_READ) || (command_q == CMD_WRITE)) begin
						reply = BYTE_ACK_B;
					end else begin
						ack = 1'b0;
					end
				end
				PH_R_RX_MSB, PH_W_RX_MSB: begin
					sect_hi_d = b;
					reply     = BYTE_ZERO;
				end
				PH_R_RX_LSB: begin
					sect_lo_d = b;
					addr_d    = sector_addr[ADDR_W-1:0];
					reply     = sect_hi_q;
				end
				PH_W_RX_LSB: begin
					sect_lo_d = b;
					addr_d    = sector_addr[ADDR_W-1:0];
					reply     = sect_hi_q;
					left_d    = SECTOR_COUNT;
				end
				PH_R_ACK1, PH_W_ACK1: begin
					reply = BYTE_ACK_A;
				end
				PH_R_ACK2, PH_W_ACK2: begin
					reply = BYTE_ACK_B;
				end
				PH_R_TX_MSB: begin
					reply = sect_hi_q;
					chk_d = sect_hi_q;
				end
				PH_R_TX_LSB: begin
					reply  = sect_lo_q;
					chk_d  = chk_q ^ sect_lo_q;
					left_d = SECTOR_COUNT;
				end
				PH_R_DATA: begin
					left_d = left_dec;
					reply  = rd_q;
					chk_d  = chk_q ^ rd_q;
					addr_d = addr_q + ADDR_W'(1);
				end
				PH_R_CHK: begin
					reply = chk_q;
				end
				PH_R_END, PH_W_END: begin
					reply = BYTE_END;
					ack   = 1'b0;
				end
				PH_W_DATA: begin
					left_d  = left_dec;
					reply   = b;
					data_we = 1'b1;
					addr_d  = addr_q + ADDR_W'(1);
					if (left_dec == 8'd0) begin
						wcount_d = wcount_q + 32'd1;
					end
				end
				PH_W_CHK, PH_W_CHK2: begin
					reply = b;
				end
				default: begin
					ack = 1'b0;
				end
			endcase
		end
	end

	// Storage write source: the clearing pass, then host data.
	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = BYTE_ZERO;
		end else begin
			mem_we = data_we;
			mem_wa = addr_q;
			mem_wd = b;
		end
	end

	// Card storage; the read port follows the next byte address.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[addr_d];
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
			if (clr_addr_q == {ADDR_W{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Protocol state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			command_q <= BYTE_ZERO;
			flag_q    <= BYTE_FLAG_RST;
			sect_hi_q <= BYTE_ZERO;
			sect_lo_q <= BYTE_ZERO;
			addr_q    <= '0;
			left_q    <= BYTE_ZERO;
			chk_q     <= BYTE_ZERO;
			wcount_q  <= 32'd0;
		end else begin
			phase_q   <= phase_d;
			command_q <= command_d;
			flag_q    <= flag_d;
			sect_hi_q <= sect_hi_d;
			sect_lo_q <= sect_lo_d;
			addr_q    <= addr_d;
			left_q    <= left_d;
			chk_q     <= chk_d;
			wcount_q  <= wcount_d;
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (response.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			reply_q <= reply;
			ack_q   <= ack;
			count_q <= wcount_d;
		end
	end

	assign response.valid           = rsp_valid_q;
	assign response.reply_byte      = reply_q;
	assign response.acknowledge     = ack_q;
	assign response.sectors_written = count_q;

endmodule
